// ===== design/real_spherical_harmonic_eval_macros.svh =====
// Assertion helpers for the spherical harmonic evaluator
`ifndef REAL_SPHERICAL_HARMONIC_EVAL_MACROS_SVH
`define REAL_SPHERICAL_HARMONIC_EVAL_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define RSHE_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rshe assertion failed");
// next-cycle implication
`define RSHE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rshe assertion failed");
`else
`define RSHE_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define RSHE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== design/rshe_pkg.sv =====
package rshe_pkg;

  localparam int MAX_BAND_DEF   = 6;
  localparam int ANGLE_BITS_DEF = 16;

  // datapath width of the signed Q30 working values
  localparam int DATA_W = 45;
  localparam int MAG_W  = DATA_W - 1;
  localparam int LO_W   = 22;

  localparam logic [31:0] ONE_Q30     = 32'h4000_0000;
  localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
  localparam longint unsigned NANO    = 64'd1000000000;

  localparam int OUT_MAX     = 524287;
  localparam int OUT_MIN_MAG = 524288;

  localparam int TAYLOR_TERMS = 6;
  localparam int QUEUE_DEPTH  = 2;
  localparam int NORM_ENTRIES = 28;

  typedef logic [31:0] norm_tab_t [NORM_ENTRIES];

  // normalization in units of 1e-9, index l*(l+1)/2 + |m|
  localparam norm_tab_t NORM_TAB = '{
    32'd282094792,
    32'd488602512, 32'd488602512,
    32'd630783131, 32'd364182810, 32'd546274215,
    32'd746352665, 32'd304697200, 32'd289061144, 32'd590043590,
    32'd846284375, 32'd267618617, 32'd189234939, 32'd252875824, 32'd625835735,
    32'd935602580, 32'd241571547, 32'd136958194, 32'd139782371, 32'd230629146,
    32'd656382057,
    32'd1017107236, 32'd221950995, 32'd105280601, 32'd87733836, 32'd112125534,
    32'd215147197, 32'd683184105
  };

  // Q30 form of the normalization, rounded, built at elaboration
  function automatic norm_tab_t make_tq();
    norm_tab_t r;
    longint unsigned v;
    for (int i = 0; i < NORM_ENTRIES; i++) begin
      v = (longint'(NORM_TAB[i]) << 30) + NANO / 2;
      r[i] = 32'(v / NANO);
    end
    return r;
  endfunction

  localparam norm_tab_t TQ_TAB = make_tq();

  typedef logic [7:0] tay_div_t [TAYLOR_TERMS];
  localparam tay_div_t TAYLOR_DIV = '{8'd156, 8'd110, 8'd72, 8'd42, 8'd20, 8'd6};

  // classified request handed from front to back
  typedef struct packed {
    logic        bad;
    logic [2:0]  band;
    logic [2:0]  am;
    logic        neg;
    logic        mz;
    logic [4:0]  tq_idx;
    logic [31:0] pth;
    logic [31:0] pph;
  } job_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] a;
    logic signed [32:0]       b;
  } mul_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] res;
  } mul_rsp_t;

  typedef struct packed {
    logic                     start;
    logic signed [DATA_W-1:0] num;
    logic [7:0]               den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

endpackage

// ===== design/rshe_if.sv =====
interface rshe_item_if;
  logic              valid;
  logic              ready;
  logic [2:0]        band;
  logic signed [3:0] order;
  logic [15:0]       polar_angle;
  logic [15:0]       azimuth_angle;
  modport source (output valid, band, order, polar_angle, azimuth_angle, input ready);
  modport sink   (input valid, band, order, polar_angle, azimuth_angle, output ready);
endinterface

interface rshe_result_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] basis_value;
  logic               bad_index;
  modport source (output valid, basis_value, bad_index, input ready);
  modport sink   (input valid, basis_value, bad_index, output ready);
endinterface

// ===== design/rshe_front.sv =====
module rshe_front #(
  parameter int MAX_BAND   = rshe_pkg::MAX_BAND_DEF,
  parameter int ANGLE_BITS = rshe_pkg::ANGLE_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  rshe_item_if.sink      item,
  input  logic           full,
  output logic           push,
  output rshe_pkg::job_t job
);

  logic           busy;
  rshe_pkg::job_t nj;
  logic [3:0]     am4;
  logic [5:0]     tri_n;
  logic [ANGLE_BITS-1:0] th_m, ph_m, ph_scaled;

  // classify the incoming request
  always_comb begin
    am4       = item.order[3] ? 4'(-item.order) : 4'(item.order);
    tri_n     = 6'(({3'b0, item.band} * ({3'b0, item.band} + 6'd1)) >> 1);
    th_m      = ANGLE_BITS'(item.polar_angle);
    ph_m      = ANGLE_BITS'(item.azimuth_angle);
    ph_scaled = ANGLE_BITS'(ph_m * am4[2:0]);
    nj.bad    = (int'(item.band) > MAX_BAND) || (am4 > {1'b0, item.band});
    nj.band   = item.band;
    nj.am     = am4[2:0];
    nj.neg    = item.order[3];
    nj.mz     = (item.order == 4'sd0);
    nj.tq_idx = 5'(tri_n) + 5'(am4[2:0]);
    nj.pth    = 32'(th_m) << (32 - ANGLE_BITS);
    nj.pph    = 32'(ph_scaled) << (32 - ANGLE_BITS);
  end

  assign item.ready = !busy || !full;
  assign push       = busy && !full;

  // one holding stage ahead of the queue
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (item.valid && item.ready) begin
      busy <= 1'b1;
      job  <= nj;
    end else if (push) begin
      busy <= 1'b0;
    end
  end

endmodule

// ===== design/rshe_queue.sv =====
module rshe_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rshe_pkg::job_t din,
  input  logic           pop,
  output rshe_pkg::job_t dout,
  output logic           full,
  output logic           empty
);

  localparam int DEPTH = rshe_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);

  rshe_pkg::job_t mem [DEPTH];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;

  assign full  = (count == (PW+1)'(DEPTH));
  assign empty = (count == '0);
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= din;
    end
  end

  // pointers wrap at the depth
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop && !empty) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push && !full) - (PW+1)'(pop && !empty);
    end
  end

endmodule

// ===== design/rshe_mulq.sv =====
module rshe_mulq (
  input  logic               clk,
  input  logic               rst,
  input  rshe_pkg::mul_req_t req,
  output rshe_pkg::mul_rsp_t rsp
);

  localparam int MAG_W = rshe_pkg::MAG_W;
  localparam int LO_W  = rshe_pkg::LO_W;
  localparam int HI_W  = MAG_W - LO_W;
  localparam int ACC_W = MAG_W + 32;

  logic [1:0]       step;
  logic [MAG_W-1:0] ua;
  logic [31:0]      ub;
  logic             neg;
  logic [ACC_W-1:0] acc;
  logic [LO_W+31:0] pp_lo;
  logic [HI_W+31:0] pp_hi;
  logic [rshe_pkg::DATA_W-1:0] shifted;
  logic             done_r;
  logic signed [rshe_pkg::DATA_W-1:0] res_r;

  // one partial product per cycle
  always_comb begin
    pp_lo   = ua[LO_W-1:0] * ub;
    pp_hi   = ua[MAG_W-1:LO_W] * ub;
    shifted = rshe_pkg::DATA_W'(acc >> 30);
  end

  assign rsp.done = done_r;
  assign rsp.res  = res_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      step   <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (step)
        2'd0: begin
          if (req.start) begin
            ua   <= req.a[rshe_pkg::DATA_W-1] ? MAG_W'(-req.a) : MAG_W'(req.a);
            ub   <= req.b[32] ? 32'(-req.b) : 32'(req.b);
            neg  <= req.a[rshe_pkg::DATA_W-1] ^ req.b[32];
            step <= 2'd1;
          end
        end
        2'd1: begin
          acc  <= ACC_W'(pp_lo);
          step <= 2'd2;
        end
        2'd2: begin
          acc  <= acc + (ACC_W'(pp_hi) << LO_W);
          step <= 2'd3;
        end
        default: begin
          // magnitude truncates, sign applied after
          res_r  <= neg ? -$signed(shifted) : $signed(shifted);
          done_r <= 1'b1;
          step   <= 2'd0;
        end
      endcase
    end
  end

endmodule

// ===== design/rshe_div.sv =====
module rshe_div (
  input  logic               clk,
  input  logic               rst,
  input  rshe_pkg::div_req_t req,
  output rshe_pkg::div_rsp_t rsp
);

  localparam int MAG_W     = rshe_pkg::MAG_W;
  localparam int RADIX_B   = 4;
  localparam int STEPS     = (MAG_W + RADIX_B - 1) / RADIX_B;
  localparam int CW        = $clog2(STEPS + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [MAG_W-1:0] qs, qs_n;
  logic [8:0]       rem, rem_n;
  logic [7:0]       den;
  logic             neg;
  logic             done_r;
  logic signed [rshe_pkg::DATA_W-1:0] quo_r;

  // four restoring steps per cycle
  always_comb begin
    rem_n = rem;
    qs_n  = qs;
    for (int k = 0; k < RADIX_B; k++) begin
      rem_n = {rem_n[7:0], qs_n[MAG_W-1]};
      qs_n  = qs_n << 1;
      if (rem_n >= {1'b0, den}) begin
        rem_n   = rem_n - {1'b0, den};
        qs_n[0] = 1'b1;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (!busy) begin
        if (req.start) begin
          qs   <= req.num[rshe_pkg::DATA_W-1] ? MAG_W'(-req.num) : MAG_W'(req.num);
          neg  <= req.num[rshe_pkg::DATA_W-1];
          den  <= req.den;
          rem  <= '0;
          cnt  <= '0;
          busy <= 1'b1;
        end
      end else begin
        qs  <= qs_n;
        rem <= rem_n;
        cnt <= cnt + 1'b1;
        if (cnt == CW'(STEPS - 1)) begin
          // quotient truncates toward zero
          quo_r  <= neg ? -$signed({1'b0, qs_n}) : $signed({1'b0, qs_n});
          done_r <= 1'b1;
          busy   <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/rshe_back.sv =====
module rshe_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  rshe_pkg::job_t     head,
  output logic               pop,
  output rshe_pkg::mul_req_t mreq,
  input  rshe_pkg::mul_rsp_t mrsp,
  output rshe_pkg::div_req_t dreq,
  input  rshe_pkg::div_rsp_t drsp,
  rshe_result_if.source      result
);

  localparam int DW    = rshe_pkg::DATA_W;
  localparam int MAG_W = rshe_pkg::MAG_W;
  localparam int RQ_W  = MAG_W - 13;

  typedef enum logic [3:0] {
    S_IDLE, S_X, S_X2, S_TM, S_TD, S_SQ, S_QUAD, S_PMM,
    S_P1, S_RM, S_RD, S_NRM, S_AZ, S_RND, S_OUT
  } state_t;

  state_t         st;
  logic           pend;
  rshe_pkg::job_t job;
  logic [1:0]     k;
  logic [2:0]     ti, cnt, n;
  logic [30:0]    ang_x, tay_t;
  logic [31:0]    ang_x2;
  logic [31:0]    sq [4];
  logic signed [DW-1:0] prod, pmm, pmmp1, p_r, y_r, num;
  logic signed [32:0]   cos_x, sin_s, ap;

  logic [31:0]    ph;
  logic [30:0]    a31, arg;
  logic [3:0]     k_p1, k_n2, k_nm;
  logic [7:0]     dn;
  logic signed [32:0] th_c, az_c, az_s;
  logic [MAG_W-1:0]   rmag;
  logic [RQ_W-1:0]    rq;
  logic signed [19:0] rval;

  function automatic logic signed [DW-1:0] op_a(input logic [31:0] v);
    return $signed(DW'(v));
  endfunction

  function automatic logic signed [32:0] op_b(input logic [31:0] v);
    return $signed({1'b0, v});
  endfunction

  function automatic logic signed [32:0] qcos(input logic [1:0] q,
                                              input logic [31:0] ca, input logic [31:0] sa);
    logic signed [32:0] r;
    case (q)
      2'd0:    r = op_b(ca);
      2'd1:    r = -op_b(sa);
      2'd2:    r = -op_b(ca);
      default: r = op_b(sa);
    endcase
    return r;
  endfunction

  function automatic logic signed [32:0] qsin(input logic [1:0] q,
                                              input logic [31:0] ca, input logic [31:0] sa);
    logic signed [32:0] r;
    case (q)
      2'd0:    r = op_b(sa);
      2'd1:    r = op_b(ca);
      2'd2:    r = -op_b(sa);
      default: r = -op_b(ca);
    endcase
    return r;
  endfunction

  // operand selection, recurrence constants, output rounding
  always_comb begin
    ph   = k[1] ? job.pph : job.pth;
    a31  = {1'b0, ph[29:0]};
    arg  = k[0] ? (31'(rshe_pkg::ONE_Q30) - a31) : a31;
    k_p1 = {job.am, 1'b1};
    k_n2 = {n, 1'b0} - 4'd1;
    k_nm = 4'(n) + 4'(job.am) - 4'd1;
    dn   = 8'(n) - 8'(job.am);
    th_c = qcos(job.pth[31:30], sq[1], sq[0]);
    az_c = qcos(job.pph[31:30], sq[3], sq[2]);
    az_s = qsin(job.pph[31:30], sq[3], sq[2]);
    num  = DW'(mrsp.res * $signed({1'b0, k_n2})) - DW'(pmm * $signed({1'b0, k_nm}));
    rmag = y_r[DW-1] ? MAG_W'(-y_r) : MAG_W'(y_r);
    rq   = RQ_W'(((MAG_W+1)'(rmag) + (MAG_W+1)'(8192)) >> 14);
    if (y_r[DW-1]) begin
      rval = (rq > RQ_W'(rshe_pkg::OUT_MIN_MAG)) ? -20'sd524288 : $signed(20'(-rq));
    end else begin
      rval = (rq > RQ_W'(rshe_pkg::OUT_MAX)) ? 20'sd524287 : $signed(20'(rq));
    end
  end

  assign pop = (st == S_IDLE) && !empty;

  // sequencer: bad indices answered at once; otherwise sines by Taylor series, then Legendre recurrence, then scaling
  always_ff @(posedge clk) begin
    if (rst) begin
      st           <= S_IDLE;
      pend         <= 1'b0;
      mreq.start   <= 1'b0;
      dreq.start   <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // start strobes last one cycle; they drop while a unit works
      if (pend) begin
        mreq.start <= 1'b0;
        dreq.start <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (!empty) begin
            job <= head;
            k   <= 2'd0;
            if (head.bad) begin
              result.valid       <= 1'b1;
              result.basis_value <= '0;
              result.bad_index   <= 1'b1;
              st                 <= S_OUT;
            end else begin
              st <= S_X;
            end
          end
        end
        S_X: begin
          if (!pend) begin
            mreq <= '{1'b1, op_a(32'(arg)), op_b(rshe_pkg::HALF_PI_Q30)};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            ang_x <= mrsp.res[30:0];
            pend  <= 1'b0;
            st    <= S_X2;
          end
        end
        S_X2: begin
          if (!pend) begin
            mreq <= '{1'b1, op_a(32'(ang_x)), op_b(32'(ang_x))};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            ang_x2 <= mrsp.res[31:0];
            tay_t  <= 31'(rshe_pkg::ONE_Q30);
            ti     <= 3'd0;
            pend   <= 1'b0;
            st     <= S_TM;
          end
        end
        S_TM: begin
          if (!pend) begin
            mreq <= '{1'b1, op_a(ang_x2), op_b(32'(tay_t))};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            prod <= mrsp.res;
            pend <= 1'b0;
            st   <= S_TD;
          end
        end
        S_TD: begin
          if (!pend) begin
            dreq <= '{1'b1, prod, rshe_pkg::TAYLOR_DIV[ti]};
            pend <= 1'b1;
          end else if (drsp.done) begin
            tay_t <= 31'(rshe_pkg::ONE_Q30) - drsp.quo[30:0];
            pend  <= 1'b0;
            if (ti == 3'(rshe_pkg::TAYLOR_TERMS - 1)) begin
              st <= S_SQ;
            end else begin
              ti <= ti + 3'd1;
              st <= S_TM;
            end
          end
        end
        S_SQ: begin
          if (!pend) begin
            mreq <= '{1'b1, op_a(32'(ang_x)), op_b(32'(tay_t))};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            sq[k] <= mrsp.res[31:0];
            pend  <= 1'b0;
            k     <= k + 2'd1;
            st    <= (k == 2'd3) ? S_QUAD : S_X;
          end
        end
        S_QUAD: begin
          // quadrant fold; polar sine taken as magnitude
          cos_x <= th_c;
          sin_s <= op_b(job.pth[30] ? sq[1] : sq[0]);
          ap    <= job.neg ? az_s : az_c;
          pmm   <= op_a(rshe_pkg::ONE_Q30);
          cnt   <= 3'd0;
          st    <= S_PMM;
        end
        S_PMM: begin
          if (!pend) begin
            if (cnt == job.am) begin
              if (job.am == job.band) begin
                p_r <= pmm;
                st  <= S_NRM;
              end else begin
                st <= S_P1;
              end
            end else begin
              mreq <= '{1'b1, pmm, sin_s};
              pend <= 1'b1;
            end
          end else if (mrsp.done) begin
            pmm  <= -mrsp.res;
            cnt  <= cnt + 3'd1;
            pend <= 1'b0;
          end
        end
        S_P1: begin
          if (!pend) begin
            mreq <= '{1'b1, pmm, cos_x};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            pmmp1 <= DW'(mrsp.res * $signed({1'b0, k_p1}));
            p_r   <= DW'(mrsp.res * $signed({1'b0, k_p1}));
            n     <= job.am + 3'd2;
            pend  <= 1'b0;
            st    <= ({1'b0, job.am} + 4'd2 > {1'b0, job.band}) ? S_NRM : S_RM;
          end
        end
        S_RM: begin
          if (!pend) begin
            mreq <= '{1'b1, pmmp1, cos_x};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            prod <= num;
            pend <= 1'b0;
            st   <= S_RD;
          end
        end
        S_RD: begin
          if (!pend) begin
            dreq <= '{1'b1, prod, dn};
            pend <= 1'b1;
          end else if (drsp.done) begin
            p_r   <= drsp.quo;
            pmm   <= pmmp1;
            pmmp1 <= drsp.quo;
            n     <= n + 3'd1;
            pend  <= 1'b0;
            st    <= ({1'b0, n} + 4'd1 > {1'b0, job.band}) ? S_NRM : S_RM;
          end
        end
        S_NRM: begin
          if (!pend) begin
            mreq <= '{1'b1, p_r, op_b(rshe_pkg::TQ_TAB[job.tq_idx])};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            y_r  <= mrsp.res;
            pend <= 1'b0;
            st   <= job.mz ? S_RND : S_AZ;
          end
        end
        S_AZ: begin
          if (!pend) begin
            mreq <= '{1'b1, y_r, ap};
            pend <= 1'b1;
          end else if (mrsp.done) begin
            y_r  <= mrsp.res;
            pend <= 1'b0;
            st   <= S_RND;
          end
        end
        S_RND: begin
          result.valid       <= 1'b1;
          result.basis_value <= rval;
          result.bad_index   <= 1'b0;
          st                 <= S_OUT;
        end
        S_OUT: begin
          if (result.ready) begin
            result.valid <= 1'b0;
            st           <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== design/real_spherical_harmonic_eval.sv =====
// Channel   Direction  Payload
// item      in         band, order, polar_angle, azimuth_angle
// result    out        basis_value, bad_index
//
// For a valid index, four Taylor sine evaluations dominate the work, each six
// multiply/divide rounds on the shared multiplier and the radix-16 divider.
// A bad index is answered from idle in the back end, with a zero basis_value.
// The front and a two-entry queue keep accepting requests, until they fill,
// while the back end works or its result waits.
// Reset is synchronous and clears all handshake and sequencer state.
`include "real_spherical_harmonic_eval_macros.svh"

module real_spherical_harmonic_eval #(
  parameter int MAX_BAND   = rshe_pkg::MAX_BAND_DEF,
  parameter int ANGLE_BITS = rshe_pkg::ANGLE_BITS_DEF
) (
  input logic           clk,
  input logic           rst,
  rshe_item_if.sink     item,
  rshe_result_if.source result
);

  logic               q_push, q_pop, q_full, q_empty;
  rshe_pkg::job_t     f_job, q_head;
  rshe_pkg::mul_req_t mreq;
  rshe_pkg::mul_rsp_t mrsp;
  rshe_pkg::div_req_t dreq;
  rshe_pkg::div_rsp_t drsp;

  rshe_front #(
    .MAX_BAND   (MAX_BAND),
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk  (clk),
    .rst  (rst),
    .item (item),
    .full (q_full),
    .push (q_push),
    .job  (f_job)
  );

  rshe_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (f_job),
    .pop   (q_pop),
    .dout  (q_head),
    .full  (q_full),
    .empty (q_empty)
  );

  rshe_mulq u_mulq (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  rshe_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  rshe_back u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (q_empty),
    .head   (q_head),
    .pop    (q_pop),
    .mreq   (mreq),
    .mrsp   (mrsp),
    .dreq   (dreq),
    .drsp   (drsp),
    .result (result)
  );

  // checks
  `RSHE_ASSERT_IMPLY(a_bad_zero, clk, rst, result.valid && result.bad_index,
                     result.basis_value == '0)
  `RSHE_ASSERT_IMPLY(a_pop_nonempty, clk, rst, q_pop, !q_empty)
  `RSHE_ASSERT_IMPLY(a_full_nonempty, clk, rst, q_full, !q_empty)
  `RSHE_ASSERT_NEXT(a_good_no_early, clk, rst, q_pop && !q_head.bad, !result.valid)

endmodule

// ===== tb/real_spherical_harmonic_eval_tb.sv =====
module real_spherical_harmonic_eval_tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [19:0] basis_value;
    logic               bad_index;
  } sh_out_t;

  logic clk;
  logic rst;

  rshe_item_if   item ();
  rshe_result_if result ();

  real_spherical_harmonic_eval DUT (
    .clk    (clk),
    .rst    (rst),
    .item   (item),
    .result (result)
  );

  sh_out_t sh_expected[$];
  int      error_count;
  int      sent_count;
  int      checked_count;
  int      bad_sent;
  bit      quiet;
  int      stall_left;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // a * b / 2^30 with the magnitude truncated
  function automatic longint q30_mul(longint a, longint b);
    bit neg;
    longint unsigned ua, ub, hi, lo, ph, pl, r;
    neg = (a < 0) != (b < 0);
    ua  = a < 0 ? -a : a;
    ub  = b < 0 ? -b : b;
    hi  = ua >> 25;
    lo  = ua & ((64'd1 << 25) - 1);
    ph  = hi * ub;
    pl  = lo * ub;
    r   = (ph >> 5) + ((((ph & 64'd31) << 25) + pl) >> 30);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  // Taylor sine of a quarter-turn fraction in Q30
  function automatic longint quarter_sine(longint unsigned a);
    longint unsigned x, x2, t;
    x  = (a * 64'(rshe_pkg::HALF_PI_Q30)) >> 30;
    x2 = (x * x) >> 30;
    t  = 64'(rshe_pkg::ONE_Q30);
    for (int i = 0; i < rshe_pkg::TAYLOR_TERMS; i++)
      t = 64'(rshe_pkg::ONE_Q30) - ((x2 * t) >> 30) / 64'(rshe_pkg::TAYLOR_DIV[i]);
    return longint'((x * t) >> 30);
  endfunction

  // cosine and sine of a 32-bit phase, quadrant by sign and swap
  function automatic void phase_trig(logic [31:0] p, output longint c, output longint s);
    longint unsigned a;
    longint sa, ca;
    a  = 64'(p[29:0]);
    sa = quarter_sine(a);
    ca = quarter_sine(64'(rshe_pkg::ONE_Q30) - a);
    case (p[31:30])
      2'd0: begin c = ca;  s = sa;  end
      2'd1: begin c = -sa; s = ca;  end
      2'd2: begin c = -ca; s = -sa; end
      default: begin c = sa; s = -ca; end
    endcase
  endfunction

  function automatic sh_out_t harmonic_value(logic [2:0] l, logic signed [3:0] m,
                                             logic [15:0] th, logic [15:0] ph);
    sh_out_t o;
    int am, idx;
    longint x, s, pmm, pmmp1, p, y, tq, cp, sp;
    longint unsigned mag, r;
    logic [15:0] mphi;
    am = m < 0 ? -int'(m) : int'(m);
    o  = '0;
    if (int'(l) > rshe_pkg::MAX_BAND_DEF || am > int'(l)) begin
      o.bad_index = 1'b1;
      return o;
    end
    phase_trig({th, 16'h0}, x, s);
    if (s < 0) s = -s;
    pmm = longint'(rshe_pkg::ONE_Q30);
    for (int i = 0; i < am; i++) pmm = -q30_mul(pmm, s);
    if (int'(l) == am) begin
      p = pmm;
    end else begin
      pmmp1 = longint'(2 * am + 1) * q30_mul(x, pmm);
      p = pmmp1;
      for (int n = am + 2; n <= int'(l); n++) begin
        p = (longint'(2 * n - 1) * q30_mul(x, pmmp1) - longint'(n + am - 1) * pmm)
            / longint'(n - am);
        pmm   = pmmp1;
        pmmp1 = p;
      end
    end
    idx = int'(l) * (int'(l) + 1) / 2 + am;
    tq  = longint'(((64'(rshe_pkg::NORM_TAB[idx]) << 30) + rshe_pkg::NANO / 2)
                   / rshe_pkg::NANO);
    y   = q30_mul(p, tq);
    if (m != 0) begin
      mphi = 16'(am * int'(ph));
      phase_trig({mphi, 16'h0}, cp, sp);
      y = q30_mul(y, m > 0 ? cp : sp);
    end
    mag = y < 0 ? -y : y;
    r   = (mag + 64'd8192) >> 14;
    if (y < 0)
      o.basis_value = r > 64'd524288 ? -20'sd524288 : 20'(-longint'(r));
    else
      o.basis_value = r > 64'(rshe_pkg::OUT_MAX) ? 20'(rshe_pkg::OUT_MAX) : 20'(r);
    return o;
  endfunction

  task automatic report_mismatch(string what);
    error_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // one request; an optional idle burst comes before it
  task automatic send_request(logic [2:0] l, logic signed [3:0] m,
                              logic [15:0] th, logic [15:0] ph);
    int gap;
    gap = (!quiet && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      item.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    item.valid         <= 1'b1;
    item.band          <= l;
    item.order         <= m;
    item.polar_angle   <= th;
    item.azimuth_angle <= ph;
    @(posedge clk);
    while (!item.ready) @(posedge clk);
    sent_count++;
    if (m < 0 ? (-int'(m) > int'(l)) : (int'(m) > int'(l))) bad_sent++;
    else if (l > 3'd6) bad_sent++;
  endtask

  // result side stalls in bursts
  always @(negedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      stall_left   = 0;
    end else if (stall_left > 0) begin
      result.ready <= 1'b0;
      stall_left--;
    end else begin
      result.ready <= 1'b1;
      if (!quiet && $urandom_range(0, 5) == 0) stall_left = $urandom_range(1, 9);
    end
  end

  // predict accepted requests, check accepted results
  always @(posedge clk) begin
    sh_out_t want;
    if (!rst) begin
      if (item.valid && item.ready)
        sh_expected.push_back(harmonic_value(item.band, item.order,
                                             item.polar_angle, item.azimuth_angle));
      if (result.valid && result.ready) begin
        if (sh_expected.size() == 0) begin
          report_mismatch("result with no request pending");
        end else begin
          want = sh_expected.pop_front();
          checked_count++;
          if (result.bad_index !== want.bad_index)
            report_mismatch($sformatf("bad_index got %b want %b",
                                      result.bad_index, want.bad_index));
          if (result.basis_value !== want.basis_value)
            report_mismatch($sformatf("basis_value got %0d want %0d",
                                      result.basis_value, want.basis_value));
        end
      end
    end
  end

  task automatic test_extremes();
    send_request(3'd0, 4'sd0, 16'd0, 16'd0);
    send_request(3'd0, 4'sd0, 16'd32768, 16'd65535);
    send_request(3'd6, 4'sd6, 16'd16384, 16'd65535);
    send_request(3'd6, -4'sd6, 16'd16384, 16'd65535);
    send_request(3'd6, 4'sd0, 16'd0, 16'd0);
    send_request(3'd6, 4'sd0, 16'd32768, 16'd0);
    send_request(3'd6, 4'sd1, 16'd8192, 16'd16384);
    send_request(3'd6, -4'sd1, 16'd8192, 16'd16384);
    send_request(3'd5, 4'sd3, 16'd65535, 16'd49152);
    send_request(3'd4, -4'sd2, 16'd49152, 16'd12345);
    send_request(3'd1, 4'sd1, 16'd1, 16'd1);
    send_request(3'd2, -4'sd2, 16'd32767, 16'd32768);
    send_request(3'd3, 4'sd3, 16'd16384, 16'd0);
  endtask

  task automatic test_bad_index();
    send_request(3'd7, 4'sd0, 16'd100, 16'd200);
    send_request(3'd6, -4'sd8, 16'd100, 16'd200);
    send_request(3'd6, 4'sd7, 16'd100, 16'd200);
    send_request(3'd0, 4'sd1, 16'd65535, 16'd65535);
    send_request(3'd2, -4'sd3, 16'd0, 16'd0);
    send_request(3'd7, -4'sd7, 16'd65535, 16'd65535);
  endtask

  task automatic random_request();
    logic [2:0] l;
    logic signed [3:0] m;
    logic [15:0] th;
    if ($urandom_range(0, 9) == 0) begin
      l = 3'($urandom);
      m = 4'($urandom);
    end else begin
      l = 3'($urandom_range(0, 6));
      m = 4'($urandom_range(0, 2 * l) - l);
    end
    th = $urandom_range(0, 7) == 0 ? 16'($urandom) : 16'($urandom_range(0, 32768));
    send_request(l, m, th, 16'($urandom));
  endtask

  task automatic test_random(int count);
    repeat (count) random_request();
  endtask

  task automatic test_no_idle(int count);
    quiet = 1'b1;
    repeat (count) random_request();
  endtask

  initial begin
    rst                = 1'b1;
    item.valid         = 1'b0;
    item.band          = '0;
    item.order         = '0;
    item.polar_angle   = '0;
    item.azimuth_angle = '0;
    error_count        = 0;
    quiet              = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extremes();
    test_bad_index();
    test_random(400);
    test_no_idle(80);
    @(negedge clk);
    item.valid <= 1'b0;
    while (sh_expected.size() != 0) @(posedge clk);
    repeat (700) @(posedge clk);
    $display("Sent %0d requests (%0d with a bad index), checked %0d results.",
             sent_count, bad_sent, checked_count);
    $display("Covered bands 0..7, orders -8..7, full angle range, random stalls.");
    if (error_count == 0 && sh_expected.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #40ms;
    $display("Timeout with %0d results outstanding", sh_expected.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+design
design/rshe_pkg.sv
design/rshe_if.sv
design/rshe_front.sv
design/rshe_queue.sv
design/rshe_mulq.sv
design/rshe_div.sv
design/rshe_back.sv
design/real_spherical_harmonic_eval.sv
tb/real_spherical_harmonic_eval_tb.sv
